### hw/rtl/foac_pkg.sv
// ----------------------------------------------------------------------------
// foac_pkg
// Shared types, constants and color tables of the flag overlay compositor.
// ----------------------------------------------------------------------------
package foac_pkg;

	localparam logic [10:0] GRID_MAX = 11'd1024;

	typedef struct packed {
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
		logic [7:0] a;
	} rgba_t;

	typedef enum logic [1:0] {
		R_VALUE_MASK,
		R_USAGE_MASK,
		R_VALUE_WIDTH,
		R_GRID_SIZE
	} reg_t;

	typedef enum logic [2:0] {
		U_WAIT,
		U_CHECK,
		U_NOP,
		U_BCLR,
		U_REM,
		U_MIX,
		U_EMIT
	} uop_t;

	typedef enum logic [2:0] {
		C_NONE,
		C_NO_BEAT,
		C_EMPTY,
		C_VMISS,
		C_UMISS,
		C_BIT_SET,
		C_OUT_BUSY
	} cond_t;

	typedef logic [3:0] step_t;

	typedef struct packed {
		uop_t  op;
		logic  usage_sel;
		cond_t cond;
		step_t jump;
		logic  loop;
		step_t loop_to;
		step_t next;
	} uword_t;

	typedef struct packed {
		uop_t op;
		logic usage_sel;
	} ctrl_t;

	typedef struct packed {
		logic no_beat;
		logic empty;
		logic vmiss;
		logic umiss;
		logic bit_set;
		logic last_bit;
		logic out_busy;
	} flags_t;

	function automatic rgba_t value_color(input logic [2:0] b);
		rgba_t c;
		case (b)
			3'd0, 3'd5: c = '{8'd178, 8'd235, 8'd255, 8'd120};
			3'd1, 3'd6: c = '{8'd36, 8'd106, 8'd111, 8'd171};
			3'd2, 3'd7: c = '{8'd83, 8'd49, 8'd255, 8'd143};
			3'd3:       c = '{8'd229, 8'd165, 8'd1, 8'd173};
			3'd4:       c = '{8'd243, 8'd255, 8'd0, 8'd153};
			default:    c = '{8'd178, 8'd235, 8'd255, 8'd120};
		endcase
		return c;
	endfunction

	function automatic rgba_t usage_color(input logic [3:0] b);
		rgba_t c;
		case (b)
			4'd0, 4'd15: c = '{8'd197, 8'd0, 8'd0, 8'd148};
			4'd1:        c = '{8'd77, 8'd77, 8'd77, 8'd120};
			4'd2:        c = '{8'd83, 8'd160, 8'd168, 8'd156};
			4'd3:        c = '{8'd66, 8'd203, 8'd75, 8'd140};
			4'd4:        c = '{8'd207, 8'd34, 8'd152, 8'd128};
			4'd5:        c = '{8'd97, 8'd75, 8'd50, 8'd194};
			4'd6:        c = '{8'd28, 8'd103, 8'd168, 8'd179};
			4'd7:        c = '{8'd208, 8'd208, 8'd38, 8'd196};
			4'd8:        c = '{8'd190, 8'd147, 8'd62, 8'd207};
			4'd9:        c = '{8'd106, 8'd51, 8'd97, 8'd189};
			4'd10:       c = '{8'd101, 8'd197, 8'd186, 8'd204};
			4'd11:       c = '{8'd33, 8'd78, 8'd83, 8'd120};
			4'd12:       c = '{8'd55, 8'd95, 8'd239, 8'd100};
			4'd13:       c = '{8'd190, 8'd80, 8'd179, 8'd156};
			4'd14:       c = '{8'd224, 8'd255, 8'd69, 8'd115};
			default:     c = '{8'd197, 8'd0, 8'd0, 8'd148};
		endcase
		return c;
	endfunction

endpackage

### hw/rtl/foac_if.sv
// ----------------------------------------------------------------------------
// foac_if
// Valid/ready channels of the compositor: map cell in, pixel out.
// ----------------------------------------------------------------------------
interface foac_cell_if;
	logic        valid;
	logic        ready;
	logic [9:0]  x_pos;
	logic [9:0]  y_pos;
	logic [31:0] value_word;
	logic [4:0]  value_bit_offset;
	logic [31:0] usage_flags;

	modport source (
		output valid, x_pos, y_pos, value_word, value_bit_offset, usage_flags,
		input  ready
	);
	modport sink (
		input  valid, x_pos, y_pos, value_word, value_bit_offset, usage_flags,
		output ready
	);
endinterface

interface foac_pix_if;
	logic        valid;
	logic        ready;
	logic [19:0] pixel_index;
	logic [7:0]  red;
	logic [7:0]  green;
	logic [7:0]  blue;
	logic [7:0]  alpha;

	modport source (
		output valid, pixel_index, red, green, blue, alpha,
		input  ready
	);
	modport sink (
		input  valid, pixel_index, red, green, blue, alpha,
		output ready
	);
endinterface

### hw/rtl/foac_seq.sv
// ----------------------------------------------------------------------------
// foac_seq
// Step counter and control store: one control word per step, with a
// conditional jump and a bit loop per word.
// ----------------------------------------------------------------------------
module foac_seq (
	input  logic            clk,
	input  logic            arst_n,
	input  foac_pkg::flags_t flags,
	output foac_pkg::ctrl_t  ctrl
);

	localparam foac_pkg::step_t S_WAIT  = 4'd0;
	localparam foac_pkg::step_t S_CHECK = 4'd1;
	localparam foac_pkg::step_t S_VTEST = 4'd2;
	localparam foac_pkg::step_t S_VREM  = 4'd3;
	localparam foac_pkg::step_t S_VMIX  = 4'd4;
	localparam foac_pkg::step_t S_UTEST = 4'd5;
	localparam foac_pkg::step_t S_UREM  = 4'd6;
	localparam foac_pkg::step_t S_UMIX  = 4'd7;
	localparam foac_pkg::step_t S_EMIT  = 4'd8;

	function automatic foac_pkg::uword_t ucode(input foac_pkg::step_t s);
		foac_pkg::uword_t w;
		case (s)
			S_WAIT:  w = '{foac_pkg::U_WAIT, 1'b0, foac_pkg::C_NO_BEAT, S_WAIT,
				1'b0, S_WAIT, S_CHECK};
			S_CHECK: w = '{foac_pkg::U_CHECK, 1'b0, foac_pkg::C_EMPTY, S_WAIT,
				1'b0, S_WAIT, S_VTEST};
			S_VTEST: w = '{foac_pkg::U_NOP, 1'b0, foac_pkg::C_VMISS, S_UTEST,
				1'b0, S_WAIT, S_VREM};
			S_VREM:  w = '{foac_pkg::U_REM, 1'b0, foac_pkg::C_BIT_SET, S_VMIX,
				1'b1, S_VREM, S_UTEST};
			S_VMIX:  w = '{foac_pkg::U_MIX, 1'b0, foac_pkg::C_NONE, S_WAIT,
				1'b1, S_VREM, S_UTEST};
			S_UTEST: w = '{foac_pkg::U_BCLR, 1'b1, foac_pkg::C_UMISS, S_EMIT,
				1'b0, S_WAIT, S_UREM};
			S_UREM:  w = '{foac_pkg::U_REM, 1'b1, foac_pkg::C_BIT_SET, S_UMIX,
				1'b1, S_UREM, S_EMIT};
			S_UMIX:  w = '{foac_pkg::U_MIX, 1'b1, foac_pkg::C_NONE, S_WAIT,
				1'b1, S_UREM, S_EMIT};
			S_EMIT:  w = '{foac_pkg::U_EMIT, 1'b0, foac_pkg::C_OUT_BUSY, S_EMIT,
				1'b0, S_WAIT, S_WAIT};
			default: w = '{foac_pkg::U_WAIT, 1'b0, foac_pkg::C_NONE, S_WAIT,
				1'b0, S_WAIT, S_WAIT};
		endcase
		return w;
	endfunction

	foac_pkg::step_t  step_q;
	foac_pkg::step_t  step_d;
	foac_pkg::uword_t uw;
	logic             hit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= S_WAIT;
		end else begin
			step_q <= step_d;
		end
	end

	always_comb begin
		uw = ucode(step_q);
		case (uw.cond)
			foac_pkg::C_NO_BEAT:  hit = flags.no_beat;
			foac_pkg::C_EMPTY:    hit = flags.empty;
			foac_pkg::C_VMISS:    hit = flags.vmiss;
			foac_pkg::C_UMISS:    hit = flags.umiss;
			foac_pkg::C_BIT_SET:  hit = flags.bit_set;
			foac_pkg::C_OUT_BUSY: hit = flags.out_busy;
			default:              hit = 1'b0;
		endcase
		if (hit) begin
			step_d = uw.jump;
		end else if (uw.loop && !flags.last_bit) begin
			step_d = uw.loop_to;
		end else begin
			step_d = uw.next;
		end
		ctrl.op        = uw.op;
		ctrl.usage_sel = uw.usage_sel;
	end

endmodule

### hw/rtl/flag_overlay_alpha_compositor.sv
// ----------------------------------------------------------------------------
// flag_overlay_alpha_compositor
// Blends fixed flag colors over a kept working color for each map cell and
// emits the pixel index with the composited RGBA.
// ----------------------------------------------------------------------------
// One cell at a time. A cell whose value field and usage flags are both zero
// gives no pixel. Any other cell passes the check and test steps, walks the
// value flag bits when the value field passes value_mask and the usage flag
// bits when the usage flags pass usage_mask, blends each set flag bit, and
// the emit step holds while the previous pixel is still unread. The step
// sequencer runs one control word per cycle
// and walks the flag bits one per step, each blend taking a remainder step
// and a mix step built on 8x8 products. A finished pixel waits in the output
// register while the next cell is taken.
// ----------------------------------------------------------------------------
module flag_overlay_alpha_compositor (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [1:0]        cfg_index,
	input  logic [31:0]       cfg_data,
	foac_cell_if.sink         tile,
	foac_pix_if.source        pix
);

	logic [31:0]        vmask_q;
	logic [31:0]        umask_q;
	logic [4:0]         vwidth_q;
	logic [10:0]        gsize_q;

	logic [31:0]        field_q;
	logic [31:0]        usage_q;
	logic [19:0]        idx_q;
	foac_pkg::rgba_t    wc_q;
	logic [3:0]         bit_q;
	logic [7:0]         rem_q;
	foac_pkg::rgba_t    src_q;
	logic [15:0]        prem_r_q;
	logic [15:0]        prem_g_q;
	logic [15:0]        prem_b_q;

	logic               pix_valid_q;
	logic [19:0]        pix_index_q;
	foac_pkg::rgba_t    pix_color_q;

	foac_pkg::ctrl_t    ctrl;
	foac_pkg::flags_t   flags;

	logic               accept;
	logic [31:0]        shl;
	logic [31:0]        field_c;
	logic [10:0]        gsat;
	logic [20:0]        idx_full;
	foac_pkg::rgba_t    src_c;
	logic [15:0]        rem_full;
	logic [16:0]        mix_r;
	logic [16:0]        mix_g;
	logic [16:0]        mix_b;
	logic               copy;
	logic [7:0]         field_lo;
	logic [15:0]        usage_lo;

	foac_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.flags  (flags),
		.ctrl   (ctrl)
	);

	assign tile.ready = (ctrl.op == foac_pkg::U_WAIT);
	assign accept     = tile.valid && tile.ready;

	assign shl      = tile.value_word << tile.value_bit_offset;
	assign field_c  = shl >> (6'd32 - {1'b0, vwidth_q});
	assign gsat     = (gsize_q > foac_pkg::GRID_MAX) ? foac_pkg::GRID_MAX : gsize_q;
	assign idx_full = 21'(tile.y_pos) * 21'(gsat) + 21'(tile.x_pos);

	assign src_c = ctrl.usage_sel ? foac_pkg::usage_color(bit_q)
		: foac_pkg::value_color(bit_q[2:0]);
	assign rem_full = 16'(wc_q.a) * 16'(8'd255 - src_c.a);

	assign mix_r = 17'(prem_r_q) + 17'(16'(wc_q.r) * 16'(rem_q));
	assign mix_g = 17'(prem_g_q) + 17'(16'(wc_q.g) * 16'(rem_q));
	assign mix_b = 17'(prem_b_q) + 17'(16'(wc_q.b) * 16'(rem_q));
	assign copy  = (wc_q.a == 8'd0) || (src_q.a == 8'd255);

	assign field_lo = field_q[7:0];
	assign usage_lo = usage_q[15:0];

	always_comb begin
		flags.no_beat  = !tile.valid;
		flags.empty    = (field_q == 32'd0) && (usage_q == 32'd0);
		flags.vmiss    = (field_q & vmask_q) == 32'd0;
		flags.umiss    = (usage_q & umask_q) == 32'd0;
		flags.bit_set  = ctrl.usage_sel ? usage_lo[bit_q] : field_lo[bit_q[2:0]];
		flags.last_bit = ctrl.usage_sel ? (bit_q == 4'd15) : (bit_q[2:0] == 3'd7);
		flags.out_busy = pix_valid_q && !pix.ready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vmask_q  <= 32'hFFFF_FFFF;
			umask_q  <= 32'hFFFF_FFFF;
			vwidth_q <= 5'd8;
			gsize_q  <= 11'd1024;
		end else if (cfg_we) begin
			case (foac_pkg::reg_t'(cfg_index))
				foac_pkg::R_VALUE_MASK:  vmask_q  <= cfg_data;
				foac_pkg::R_USAGE_MASK:  umask_q  <= cfg_data;
				foac_pkg::R_VALUE_WIDTH: vwidth_q <= cfg_data[4:0];
				foac_pkg::R_GRID_SIZE:   gsize_q  <= cfg_data[10:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			field_q <= field_c;
			usage_q <= tile.usage_flags;
			idx_q   <= idx_full[19:0];
		end
		if (ctrl.op == foac_pkg::U_REM && flags.bit_set) begin
			rem_q    <= rem_full[15:8];
			src_q    <= src_c;
			prem_r_q <= 16'(src_c.r) * 16'(src_c.a);
			prem_g_q <= 16'(src_c.g) * 16'(src_c.a);
			prem_b_q <= 16'(src_c.b) * 16'(src_c.a);
		end
		if (ctrl.op == foac_pkg::U_EMIT && !flags.out_busy) begin
			pix_index_q <= idx_q;
			pix_color_q <= wc_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wc_q        <= '0;
			bit_q       <= 4'd0;
			pix_valid_q <= 1'b0;
		end else begin
			case (ctrl.op)
				foac_pkg::U_CHECK: begin
					bit_q <= 4'd0;
					if (!flags.empty) begin
						wc_q.a <= 8'd0;
					end
				end
				foac_pkg::U_BCLR: begin
					bit_q <= 4'd0;
				end
				foac_pkg::U_REM: begin
					if (!flags.bit_set) begin
						bit_q <= bit_q + 4'd1;
					end
				end
				foac_pkg::U_MIX: begin
					bit_q <= bit_q + 4'd1;
					if (copy) begin
						wc_q <= src_q;
					end else begin
						wc_q.r <= mix_r[15:8];
						wc_q.g <= mix_g[15:8];
						wc_q.b <= mix_b[15:8];
						wc_q.a <= src_q.a;
					end
				end
				default: ;
			endcase
			if (ctrl.op == foac_pkg::U_EMIT && !flags.out_busy) begin
				pix_valid_q <= 1'b1;
			end else if (pix.ready) begin
				pix_valid_q <= 1'b0;
			end
		end
	end

	assign pix.valid       = pix_valid_q;
	assign pix.pixel_index = pix_index_q;
	assign pix.red         = pix_color_q.r;
	assign pix.green       = pix_color_q.g;
	assign pix.blue        = pix_color_q.b;
	assign pix.alpha       = pix_color_q.a;

`ifndef NO_ASSERTIONS
	a_accept_to_check: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> ctrl.op == foac_pkg::U_CHECK)
		else $error("cell beat not followed by check step");

	a_emit_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(ctrl.op == foac_pkg::U_EMIT && !flags.out_busy) |=> pix_valid_q)
		else $error("emit step did not load output register");

	a_alpha_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(ctrl.op == foac_pkg::U_CHECK && !flags.empty) |=> wc_q.a == 8'd0)
		else $error("working alpha not cleared for drawn cell");

	a_value_bit_range: assert property (@(posedge clk) disable iff (!arst_n)
		(ctrl.op == foac_pkg::U_CHECK) |=> bit_q == 4'd0)
		else $error("bit counter not cleared at cell start");
`endif

endmodule

### tb/sv/tb_flag_overlay_alpha_compositor.sv
// ----------------------------------------------------------------------------
// tb_flag_overlay_alpha_compositor
// Drives map cells into the compositor and checks every pixel it emits. A
// directed table covers the extremes of the cell fields, single flag colors,
// fields that run past the end of the word and skipped cells. Random cells then
// follow under a series of register settings, with both channels stalling at
// random until 1200 cells are sent. An in-bench color blender keeps its own
// copy of the working color and of the registers and predicts each pixel that the table does not give.
// ----------------------------------------------------------------------------
module tb_flag_overlay_alpha_compositor;

	localparam int QUIET_CYCLES = 60;
	localparam int PHASE_CELLS  = 225;
	localparam int PHASES       = 8;

	typedef struct packed {
		logic [9:0]  x;
		logic [9:0]  y;
		logic [31:0] word;
		logic [4:0]  off;
		logic [31:0] usage;
	} cell_t;

	typedef struct packed {
		logic [19:0]     index;
		foac_pkg::rgba_t color;
	} pixel_t;

	typedef struct packed {
		cell_t  c;
		logic   typed;
		pixel_t want;
	} row_t;

	localparam foac_pkg::rgba_t VALUE_TINTS [5] = '{
		'{8'd178, 8'd235, 8'd255, 8'd120}, '{8'd36, 8'd106, 8'd111, 8'd171},
		'{8'd83, 8'd49, 8'd255, 8'd143}, '{8'd229, 8'd165, 8'd1, 8'd173},
		'{8'd243, 8'd255, 8'd0, 8'd153}
	};

	localparam foac_pkg::rgba_t USAGE_TINTS [15] = '{
		'{8'd197, 8'd0, 8'd0, 8'd148}, '{8'd77, 8'd77, 8'd77, 8'd120},
		'{8'd83, 8'd160, 8'd168, 8'd156}, '{8'd66, 8'd203, 8'd75, 8'd140},
		'{8'd207, 8'd34, 8'd152, 8'd128}, '{8'd97, 8'd75, 8'd50, 8'd194},
		'{8'd28, 8'd103, 8'd168, 8'd179}, '{8'd208, 8'd208, 8'd38, 8'd196},
		'{8'd190, 8'd147, 8'd62, 8'd207}, '{8'd106, 8'd51, 8'd97, 8'd189},
		'{8'd101, 8'd197, 8'd186, 8'd204}, '{8'd33, 8'd78, 8'd83, 8'd120},
		'{8'd55, 8'd95, 8'd239, 8'd100}, '{8'd190, 8'd80, 8'd179, 8'd156},
		'{8'd224, 8'd255, 8'd69, 8'd115}
	};

	localparam pixel_t NO_PIXEL = '0;
	localparam int DIRECTED_ROWS = 21;

	localparam row_t DIRECTED [DIRECTED_ROWS] = '{
		'{'{10'd0, 10'd0, 32'h0, 5'd0, 32'h0}, 1'b0, NO_PIXEL},
		'{'{10'd1023, 10'd1023, 32'h0, 5'd0, 32'h1}, 1'b1,
			'{20'hFFFFF, '{8'd197, 8'd0, 8'd0, 8'd148}}},
		'{'{10'd0, 10'd0, 32'h80000000, 5'd0, 32'h0}, 1'b1,
			'{20'd0, '{8'd83, 8'd49, 8'd255, 8'd143}}},
		'{'{10'd5, 10'd0, 32'h01000000, 5'd0, 32'h0}, 1'b1,
			'{20'd5, '{8'd178, 8'd235, 8'd255, 8'd120}}},
		'{'{10'd3, 10'd2, 32'h10000000, 5'd0, 32'h0}, 1'b1,
			'{20'd2051, '{8'd243, 8'd255, 8'd0, 8'd153}}},
		'{'{10'd0, 10'd1, 32'h20000000, 5'd0, 32'h0}, 1'b1,
			'{20'd1024, '{8'd178, 8'd235, 8'd255, 8'd120}}},
		'{'{10'd7, 10'd0, 32'h1, 5'd31, 32'h0}, 1'b1,
			'{20'd7, '{8'd83, 8'd49, 8'd255, 8'd143}}},
		'{'{10'd100, 10'd200, 32'hF, 5'd28, 32'h0}, 1'b0, NO_PIXEL},
		'{'{10'd1023, 10'd0, 32'h7F, 5'd25, 32'h0}, 1'b0, NO_PIXEL},
		'{'{10'd9, 10'd9, 32'h00FFFFFF, 5'd0, 32'h0}, 1'b0, NO_PIXEL},
		'{'{10'd10, 10'd10, 32'h0, 5'd0, 32'h80000000}, 1'b0, NO_PIXEL},
		'{'{10'd0, 10'd1023, 32'h0, 5'd0, 32'h8000}, 1'b1,
			'{20'd1047552, '{8'd197, 8'd0, 8'd0, 8'd148}}},
		'{'{10'd1, 10'd0, 32'h0, 5'd0, 32'h4000}, 1'b1,
			'{20'd1, '{8'd224, 8'd255, 8'd69, 8'd115}}},
		'{'{10'd2, 10'd3, 32'h0, 5'd0, 32'h3}, 1'b0, NO_PIXEL},
		'{'{10'd4, 10'd4, 32'hFFFFFFFF, 5'd0, 32'hFFFFFFFF}, 1'b0, NO_PIXEL},
		'{'{10'd1023, 10'd1023, 32'hFFFFFFFF, 5'd31, 32'h0000FFFF}, 1'b0, NO_PIXEL},
		'{'{10'd512, 10'd511, 32'hAAAAAAAA, 5'd3, 32'h55555555}, 1'b0, NO_PIXEL},
		'{'{10'd341, 10'd682, 32'h55555555, 5'd12, 32'hAAAA0000}, 1'b0, NO_PIXEL},
		'{'{10'd0, 10'd0, 32'h0, 5'd31, 32'h00010000}, 1'b0, NO_PIXEL},
		'{'{10'd1023, 10'd0, 32'h00FF0000, 5'd8, 32'h0}, 1'b0, NO_PIXEL},
		'{'{10'd1023, 10'd1023, 32'h0, 5'd31, 32'h0}, 1'b0, NO_PIXEL}
	};

	logic              clk;
	logic              arst_n;
	logic              cfg_we;
	foac_pkg::reg_t    cfg_index;
	logic [31:0]       cfg_data;

	foac_cell_if tile ();
	foac_pix_if  pix ();

	flag_overlay_alpha_compositor dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.tile      (tile),
		.pix       (pix)
	);

	logic [31:0]     vmask;
	logic [31:0]     umask;
	logic [4:0]      field_width;
	logic [10:0]     grid_side;
	foac_pkg::rgba_t brush;

	pixel_t pending_pixels [$];
	int     errors;
	int     cells_sent;
	int     tx_idle_pct;
	int     rx_idle_pct;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#10_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

	function automatic void lay_tint(input foac_pkg::rgba_t s);
		logic [31:0] rem;
		if (brush.a == 8'd0 || s.a == 8'd255) begin
			brush = s;
		end else begin
			rem = (32'(brush.a) * (32'd255 - 32'(s.a))) >> 8;
			brush.r = 8'((32'(s.r) * 32'(s.a) + 32'(brush.r) * rem) >> 8);
			brush.g = 8'((32'(s.g) * 32'(s.a) + 32'(brush.g) * rem) >> 8);
			brush.b = 8'((32'(s.b) * 32'(s.a) + 32'(brush.b) * rem) >> 8);
			brush.a = 8'(32'(s.a) + (rem >> 8));
		end
	endfunction

	function automatic bit composite_cell(input cell_t c, output pixel_t p);
		logic [63:0] wide;
		logic [31:0] field;
		logic [31:0] span;
		int          sh;
		field = '0;
		p = '0;
		if (field_width != 5'd0) begin
			wide = {c.word, 32'h0};
			sh = 64 - int'(field_width) - int'(c.off);
			field = 32'((wide >> sh) & ((64'd1 << field_width) - 64'd1));
		end
		if (field == 32'd0 && c.usage == 32'd0)
			return 1'b0;
		brush.a = 8'd0;
		if ((field & vmask) != 32'd0) begin
			for (int b = 0; b < 8; b++)
				if (field[b])
					lay_tint(VALUE_TINTS[b % 5]);
		end
		if ((c.usage & umask) != 32'd0) begin
			for (int b = 0; b < 16; b++)
				if (c.usage[b])
					lay_tint(USAGE_TINTS[b % 15]);
		end
		span = (grid_side > foac_pkg::GRID_MAX) ? 32'(foac_pkg::GRID_MAX)
			: 32'(grid_side);
		p.index = 20'(32'(c.y) * span + 32'(c.x));
		p.color = brush;
		return 1'b1;
	endfunction

	function automatic cell_t random_cell();
		cell_t c;
		int    kind;
		kind = $urandom_range(0, 9);
		c.x = 10'($urandom);
		c.y = 10'($urandom);
		c.word = $urandom;
		c.off = 5'($urandom);
		c.usage = $urandom;
		case (kind)
			0: begin
				c.word = 32'h0;
				c.usage = 32'h0;
			end
			1, 2: c.usage = 32'h0;
			3, 4: c.usage = $urandom & $urandom & 32'h0000FFFF;
			5: c.usage = $urandom & 32'hFFFF0000;
			default: ;
		endcase
		return c;
	endfunction

	task automatic send_cell(input cell_t c, input bit typed, input pixel_t want);
		pixel_t p;
		bit     hit;
		while (tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct) begin
			tile.valid <= 1'b0;
			@(posedge clk);
		end
		tile.valid <= 1'b1;
		tile.x_pos <= c.x;
		tile.y_pos <= c.y;
		tile.value_word <= c.word;
		tile.value_bit_offset <= c.off;
		tile.usage_flags <= c.usage;
		@(posedge clk);
		while (!tile.ready)
			@(posedge clk);
		hit = composite_cell(c, p);
		if (typed)
			pending_pixels.push_back(want);
		else if (hit)
			pending_pixels.push_back(p);
		cells_sent++;
	endtask

	task automatic drain_pixels();
		tile.valid <= 1'b0;
		while (pending_pixels.size() != 0)
			@(posedge clk);
		repeat (QUIET_CYCLES) @(posedge clk);
	endtask

	task automatic apply_setting(input logic [31:0] vm, input logic [31:0] um,
			input logic [31:0] vw, input logic [31:0] gs);
		logic [31:0]    vals [4];
		foac_pkg::reg_t regs [4];
		vals = '{vm, um, vw, gs};
		regs = '{foac_pkg::R_VALUE_MASK, foac_pkg::R_USAGE_MASK,
			foac_pkg::R_VALUE_WIDTH, foac_pkg::R_GRID_SIZE};
		for (int i = 0; i < 4; i++) begin
			cfg_we <= 1'b1;
			cfg_index <= regs[i];
			cfg_data <= vals[i];
			@(posedge clk);
			case (regs[i])
				foac_pkg::R_VALUE_MASK:  vmask = vals[i];
				foac_pkg::R_USAGE_MASK:  umask = vals[i];
				foac_pkg::R_VALUE_WIDTH: field_width = vals[i][4:0];
				foac_pkg::R_GRID_SIZE:   grid_side = vals[i][10:0];
				default: ;
			endcase
		end
		cfg_we <= 1'b0;
	endtask

	task automatic check_pixel();
		pixel_t want;
		if (pending_pixels.size() == 0) begin
			$display("%0t: unexpected pixel index %0d rgba %h %h %h %h", $time,
				pix.pixel_index, pix.red, pix.green, pix.blue, pix.alpha);
			errors++;
			return;
		end
		want = pending_pixels.pop_front();
		if (pix.pixel_index !== want.index) begin
			$display("%0t: pixel_index expected %0d got %0d", $time, want.index,
				pix.pixel_index);
			errors++;
		end
		if (pix.red !== want.color.r) begin
			$display("%0t: red expected %0d got %0d", $time, want.color.r, pix.red);
			errors++;
		end
		if (pix.green !== want.color.g) begin
			$display("%0t: green expected %0d got %0d", $time, want.color.g, pix.green);
			errors++;
		end
		if (pix.blue !== want.color.b) begin
			$display("%0t: blue expected %0d got %0d", $time, want.color.b, pix.blue);
			errors++;
		end
		if (pix.alpha !== want.color.a) begin
			$display("%0t: alpha expected %0d got %0d", $time, want.color.a, pix.alpha);
			errors++;
		end
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			pix.ready <= 1'b0;
		end else begin
			if (pix.valid && pix.ready)
				check_pixel();
			pix.ready <= (rx_idle_pct == 0) || ($urandom_range(0, 99) >= rx_idle_pct);
		end
	end

	task automatic pick_idling();
		if (cells_sent < 600) begin
			tx_idle_pct = 32;
			rx_idle_pct = 51;
		end else if (cells_sent < 1200) begin
			tx_idle_pct = 51;
			rx_idle_pct = 32;
		end else begin
			tx_idle_pct = 0;
			rx_idle_pct = 0;
		end
	endtask

	initial begin
		logic [31:0] vm;
		logic [31:0] um;
		logic [31:0] vw;
		logic [31:0] gs;
		pixel_t      want;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = foac_pkg::R_VALUE_MASK;
		cfg_data = '0;
		tile.valid = 1'b0;
		tile.x_pos = '0;
		tile.y_pos = '0;
		tile.value_word = '0;
		tile.value_bit_offset = '0;
		tile.usage_flags = '0;
		errors = 0;
		cells_sent = 0;
		tx_idle_pct = 32;
		rx_idle_pct = 51;
		vmask = 32'hFFFFFFFF;
		umask = 32'hFFFFFFFF;
		field_width = 5'd8;
		grid_side = 11'd1024;
		brush = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < DIRECTED_ROWS; i++) begin
			pick_idling();
			send_cell(DIRECTED[i].c, DIRECTED[i].typed, DIRECTED[i].want);
		end

		for (int ph = 0; ph < PHASES; ph++) begin
			drain_pixels();
			case (ph)
				0: begin
					vm = 32'hFFFFFFFF;
					um = 32'hFFFFFFFF;
					vw = 32'd8;
					gs = 32'd1024;
				end
				1: begin
					vm = 32'h0;
					um = 32'hFFFFFFFF;
					vw = 32'd16;
					gs = 32'd1;
				end
				2: begin
					vm = 32'hFFFFFFFF;
					um = 32'h0;
					vw = 32'hFFFFFFE1;
					gs = 32'hFFFFF800;
				end
				3: begin
					vm = $urandom;
					um = $urandom;
					vw = 32'd31;
					gs = 32'd2047;
				end
				4: begin
					vm = 32'h0;
					um = 32'h0;
					vw = 32'd0;
					gs = 32'd37;
				end
				default: begin
					vm = $urandom & $urandom;
					um = $urandom & $urandom;
					vw = ($urandom & ~32'h1F) | 32'($urandom_range(1, 16));
					gs = ($urandom & ~32'h7FF) | 32'($urandom_range(1, 1024));
				end
			endcase
			apply_setting(vm, um, vw, gs);
			for (int n = 0; n < PHASE_CELLS; n++) begin
				pick_idling();
				send_cell(random_cell(), 1'b0, NO_PIXEL);
			end
		end

		drain_pixels();
		while (pending_pixels.size() != 0) begin
			want = pending_pixels.pop_front();
			$display("%0t: missing pixel index %0d rgba %h", $time, want.index, want.color);
			errors++;
		end
		if (errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

### flag_overlay_alpha_compositor.f
hw/rtl/foac_pkg.sv
hw/rtl/foac_if.sv
hw/rtl/foac_seq.sv
hw/rtl/flag_overlay_alpha_compositor.sv
tb/sv/tb_flag_overlay_alpha_compositor.sv
